FILE: design/efe_pkg.sv
// ----------------------------------------------------------------------------
// efe_pkg
// Shared constants and codes for the flash EEPROM emulation log.
// ----------------------------------------------------------------------------
package efe_pkg;
    localparam int SECTORS      = 4;
    localparam int RAW_SLOTS    = 128;
    localparam int HEADER_SLOTS = 3;
    localparam int DATA_SLOTS   = RAW_SLOTS - HEADER_SLOTS;
    localparam int SEC_W        = $clog2(SECTORS);
    localparam int SLOT_W       = $clog2(RAW_SLOTS);
    localparam int ADDR_W       = SEC_W + SLOT_W;
    localparam int DEPTH        = SECTORS * RAW_SLOTS;
    localparam int IDX_W        = 7;
    localparam int DATA_W       = 64;
    localparam int CNT_W        = 7;
    localparam int MEM_W        = IDX_W + DATA_W;
    localparam int IN_W         = 72;
    localparam int OUT_W        = 80;

    localparam logic [2:0] OUT_READ    = 3'd0;
    localparam logic [2:0] OUT_SAME    = 3'd1;
    localparam logic [2:0] OUT_APPEND  = 3'd2;
    localparam logic [2:0] OUT_COMPACT = 3'd3;
    localparam logic [2:0] OUT_RANGE   = 3'd4;

    localparam logic [IDX_W-1:0] FILE_BLOCKS_RST = 7'd64;
endpackage

FILE: design/efe_ram.sv
// ----------------------------------------------------------------------------
// efe_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module efe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/efe_ctrl.sv
// ----------------------------------------------------------------------------
// efe_ctrl
// Request sequencer: scans the slot log, appends, compacts, builds results.
// ----------------------------------------------------------------------------
module efe_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [efe_pkg::IDX_W-1:0]   file_blocks,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [efe_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [efe_pkg::OUT_W-1:0]   m_tdata,
    output logic                        mem_we,
    output logic [efe_pkg::ADDR_W-1:0]  mem_waddr,
    output logic [efe_pkg::MEM_W-1:0]   mem_wdata,
    output logic [efe_pkg::ADDR_W-1:0]  mem_raddr,
    input  logic [efe_pkg::MEM_W-1:0]   mem_rdata
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOK   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_CPNEXT = 3'd3;
    localparam logic [2:0] ST_CPPUT  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    localparam int SCAN_W = efe_pkg::SLOT_W + 1;
    localparam logic [SCAN_W-1:0] RAW_V = SCAN_W'(efe_pkg::RAW_SLOTS);
    localparam logic [SCAN_W-1:0] HDR_V = SCAN_W'(efe_pkg::HEADER_SLOTS);
    localparam logic [efe_pkg::CNT_W-1:0] DATA_V = efe_pkg::CNT_W'(efe_pkg::DATA_SLOTS);
    localparam logic [efe_pkg::SEC_W-1:0] LAST_SEC = efe_pkg::SEC_W'(efe_pkg::SECTORS - 1);

    logic [2:0]                   state_reg, state_next;
    logic                         cmd_reg, cmd_next;
    logic [efe_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [efe_pkg::DATA_W-1:0]   wd_reg, wd_next;
    logic [efe_pkg::SEC_W-1:0]    live_reg, live_next;
    logic [efe_pkg::SEC_W-1:0]    fresh_reg, fresh_next;
    logic [efe_pkg::CNT_W-1:0]    left_reg, left_next;
    logic [efe_pkg::CNT_W-1:0]    avail_reg, avail_next;
    logic [efe_pkg::IDX_W-1:0]    fb_reg, fb_next;
    logic [SCAN_W-1:0]            scan_reg, scan_next;
    logic                         pend_reg, pend_next;
    logic                         hit_reg, hit_next;
    logic                         ret_reg, ret_next;
    logic [efe_pkg::DATA_W-1:0]   cur_reg, cur_next;
    logic                         found_reg, found_next;
    logic [2:0]                   outc_reg, outc_next;
    logic [efe_pkg::DATA_W-1:0]   rd_reg, rd_next;
    logic                         mv_reg, mv_next;
    logic [efe_pkg::OUT_W-1:0]    md_reg, md_next;

    logic [efe_pkg::IDX_W-1:0]    target;
    logic [SCAN_W-1:0]            put_slot;
    logic [SCAN_W-1:0]            scan_dec;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign target   = ret_reg ? fb_reg : idx_reg;
    assign scan_dec = scan_reg - SCAN_W'(1);

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        wd_next    = wd_reg;
        live_next  = live_reg;
        fresh_next = fresh_reg;
        left_next  = left_reg;
        avail_next = avail_reg;
        fb_next    = fb_reg;
        scan_next  = scan_reg;
        pend_next  = pend_reg;
        hit_next   = hit_reg;
        ret_next   = ret_reg;
        cur_next   = cur_reg;
        found_next = found_reg;
        outc_next  = outc_reg;
        rd_next    = rd_reg;
        mv_next    = mv_reg & ~m_tready;
        md_next    = md_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = {live_reg, scan_dec[efe_pkg::SLOT_W-1:0]};
        put_slot   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_tdata[0];
                    idx_next  = s_tdata[7:1];
                    wd_next   = s_tdata[71:8];
                    rd_next   = '0;
                    found_next = 1'b0;
                    if (s_tdata[7:1] >= file_blocks) begin
                        outc_next  = efe_pkg::OUT_RANGE;
                        state_next = ST_RESULT;
                    end else begin
                        scan_next  = RAW_V - SCAN_W'(left_reg);
                        pend_next  = 1'b0;
                        ret_next   = 1'b0;
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (pend_reg && mem_rdata[efe_pkg::IDX_W-1:0] == target) begin
                    hit_next   = 1'b1;
                    cur_next   = mem_rdata[efe_pkg::MEM_W-1:efe_pkg::IDX_W];
                    state_next = ret_reg ? ST_CPPUT : ST_DECIDE;
                end else if (scan_reg > HDR_V) begin
                    scan_next = scan_dec;
                    pend_next = 1'b1;
                end else begin
                    hit_next   = 1'b0;
                    cur_next   = '1;
                    state_next = ret_reg ? ST_CPPUT : ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                found_next = hit_reg;
                if (!cmd_reg) begin
                    rd_next    = cur_reg;
                    outc_next  = efe_pkg::OUT_READ;
                    state_next = ST_RESULT;
                end else if (cur_reg == wd_reg) begin
                    outc_next  = efe_pkg::OUT_SAME;
                    state_next = ST_RESULT;
                end else if (left_reg != '0) begin
                    put_slot   = RAW_V - SCAN_W'(left_reg);
                    mem_we     = 1'b1;
                    mem_waddr  = {live_reg, put_slot[efe_pkg::SLOT_W-1:0]};
                    mem_wdata  = {wd_reg, idx_reg};
                    left_next  = left_reg - efe_pkg::CNT_W'(1);
                    outc_next  = efe_pkg::OUT_APPEND;
                    state_next = ST_RESULT;
                end else begin
                    fresh_next = (live_reg == LAST_SEC) ? '0 : live_reg + efe_pkg::SEC_W'(1);
                    avail_next = DATA_V;
                    fb_next    = '0;
                    state_next = ST_CPNEXT;
                end
            end
            ST_CPNEXT: begin
                if (fb_reg < file_blocks && avail_reg != '0) begin
                    if (fb_reg == idx_reg) begin
                        put_slot   = RAW_V - SCAN_W'(avail_reg);
                        mem_we     = 1'b1;
                        mem_waddr  = {fresh_reg, put_slot[efe_pkg::SLOT_W-1:0]};
                        mem_wdata  = {wd_reg, fb_reg};
                        avail_next = avail_reg - efe_pkg::CNT_W'(1);
                        fb_next    = fb_reg + efe_pkg::IDX_W'(1);
                    end else begin
                        scan_next  = RAW_V - SCAN_W'(left_reg);
                        pend_next  = 1'b0;
                        ret_next   = 1'b1;
                        state_next = ST_LOOK;
                    end
                end else begin
                    live_next  = fresh_reg;
                    left_next  = avail_reg;
                    outc_next  = efe_pkg::OUT_COMPACT;
                    state_next = ST_RESULT;
                end
            end
            ST_CPPUT: begin
                if (hit_reg) begin
                    put_slot   = RAW_V - SCAN_W'(avail_reg);
                    mem_we     = 1'b1;
                    mem_waddr  = {fresh_reg, put_slot[efe_pkg::SLOT_W-1:0]};
                    mem_wdata  = {cur_reg, fb_reg};
                    avail_next = avail_reg - efe_pkg::CNT_W'(1);
                end
                fb_next    = fb_reg + efe_pkg::IDX_W'(1);
                state_next = ST_CPNEXT;
            end
            ST_RESULT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {3'b000, left_reg, live_reg, outc_reg, found_reg, rd_reg};
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            live_reg  <= '0;
            left_reg  <= DATA_V;
            mv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            ret_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            live_reg  <= live_next;
            left_reg  <= left_next;
            mv_reg    <= mv_next;
            pend_reg  <= pend_next;
            ret_reg   <= ret_next;
        end
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        wd_reg    <= wd_next;
        fresh_reg <= fresh_next;
        avail_reg <= avail_next;
        fb_reg    <= fb_next;
        scan_reg  <= scan_next;
        hit_reg   <= hit_next;
        cur_reg   <= cur_next;
        found_reg <= found_next;
        outc_reg  <= outc_next;
        rd_reg    <= rd_next;
        md_reg    <= md_next;
    end
endmodule

FILE: design/flash_eeprom_emulation_log.sv
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_log
// Emulated EEPROM kept as an append-only log of tagged slots in a flash ring.
// ----------------------------------------------------------------------------
// One request at a time. A read, an unchanged write or an append scans the
// live sector's slots newest first (at most 125) and then presents its result.
// The next request can be accepted as soon as the result is presented. An
// append writes its slot in the decision state. A compaction copies every
// block in use while the new sector has free slots. The block being written
// is put straight into the new sector. Every other block takes a dispatch
// step, a scan of the old sector and, if it is found, a copy step.
// A stalled result holds back the next result, not the next acceptance.
// The slot RAM's single read port makes the scans read one slot at a time.
// No clearing pass runs after reset: only slots written since their sector went
// live are ever read.
module flash_eeprom_emulation_log (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [efe_pkg::IDX_W-1:0]  cfg_data,     // file_blocks
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [efe_pkg::IN_W-1:0]   s_tdata,      // command, block number, write data
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [efe_pkg::OUT_W-1:0]  m_tdata       // block contents, found, outcome,
                                                     // active_sector, free_slots
);
    logic [efe_pkg::IDX_W-1:0]  fblk_reg;
    logic                       mem_we;
    logic [efe_pkg::ADDR_W-1:0] mem_waddr;
    logic [efe_pkg::MEM_W-1:0]  mem_wdata;
    logic [efe_pkg::ADDR_W-1:0] mem_raddr;
    logic [efe_pkg::MEM_W-1:0]  mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fblk_reg <= efe_pkg::FILE_BLOCKS_RST;
        end else if (cfg_valid) begin
            fblk_reg <= cfg_data;
        end
    end

    efe_ram #(
        .WIDTH (efe_pkg::MEM_W),
        .DEPTH (efe_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    efe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .file_blocks (fblk_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );
endmodule

FILE: design/efe_chk.sv
// ----------------------------------------------------------------------------
// efe_chk
// Port-level checks for the flash EEPROM emulation log.
// ----------------------------------------------------------------------------
module efe_chk (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [efe_pkg::OUT_W-1:0] m_tdata
);
    a_range_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[67:65] == efe_pkg::OUT_RANGE)
            |-> (m_tdata[64] == 1'b0 && m_tdata[63:0] == '0))
        else $error("out-of-range result carries data");

    a_write_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[67:65] != efe_pkg::OUT_READ) |-> m_tdata[63:0] == '0)
        else $error("non-read result carries data");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[76:70] <= 7'(efe_pkg::DATA_SLOTS))
        else $error("free slot count too large");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
endmodule

bind flash_eeprom_emulation_log efe_chk u_efe_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
